// File: design/assert_macros.svh
// Concurrent assertion helpers. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: design/curov_pkg.sv
package curov_pkg;

  localparam int OP_W      = 2;
  localparam int WIDX_W    = 6;
  localparam int WORD_W    = 32;
  localparam int PTR_W     = 13;
  localparam int PIX_W     = 12;
  localparam int RGB_W     = 24;
  localparam int HOT_W     = 5;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;

  // Pattern geometry and display limit.
  localparam int CURSOR_WIDTH        = 32;
  localparam int CURSOR_HEIGHT_DEF   = 32;
  localparam int WORDS_PER_ROW_DEF   = 2;
  localparam int MAX_DISPLAY_DIM     = 4096;

  localparam logic [DIM_W-1:0] DISPLAY_WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0] DISPLAY_HEIGHT_RST = 13'd768;

  localparam logic [RGB_W-1:0] RGB_WHITE = 24'hffffff;
  localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000000;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_PLACE = 2'd1,
    OP_HIDE  = 2'd2,
    OP_PIXEL = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOTSPOT_X      = 2'd0,
    REG_HOTSPOT_Y      = 2'd1,
    REG_DISPLAY_WIDTH  = 2'd2,
    REG_DISPLAY_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CODE_CLEAR  = 2'd0,
    CODE_BLACK  = 2'd1,
    CODE_WHITE  = 2'd2,
    CODE_BLACK2 = 2'd3
  } code_t;

endpackage

// File: design/curov_if.sv
interface curov_in_if;
  import curov_pkg::*;

  logic                    valid;
  logic                    ready;
  op_t                     op;
  logic [WIDX_W-1:0]       word_index;
  logic [WORD_W-1:0]       word_data;
  logic signed [PTR_W-1:0] pointer_x;
  logic signed [PTR_W-1:0] pointer_y;
  logic [PIX_W-1:0]        pixel_x;
  logic [PIX_W-1:0]        pixel_y;
  logic [RGB_W-1:0]        pixel_rgb;

  modport source (
    output valid, op, word_index, word_data, pointer_x, pointer_y,
           pixel_x, pixel_y, pixel_rgb,
    input  ready
  );

  modport sink (
    input  valid, op, word_index, word_data, pointer_x, pointer_y,
           pixel_x, pixel_y, pixel_rgb,
    output ready
  );
endinterface

interface curov_out_if;
  import curov_pkg::*;

  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] rgb_out;
  logic             cursor_hit;

  modport source (
    output valid, rgb_out, cursor_hit,
    input  ready
  );

  modport sink (
    input  valid, rgb_out, cursor_hit,
    output ready
  );
endinterface

// File: design/cursor_overlay_2bpp.sv
// Pipeline: an accepted beat moves through stage A, stage B and the output register.
// Throughput: one beat per clock cycle; the three pipeline registers only stall
// when the output beat is not taken, and empty stages fill up regardless.
// Reset: rst_n is synchronous and active low; it empties the pipeline, hides the
// cursor and restores the register defaults. The pattern memory is not cleared.
module cursor_overlay_2bpp #(
  parameter int CURSOR_HEIGHT = curov_pkg::CURSOR_HEIGHT_DEF,
  parameter int WORDS_PER_ROW = curov_pkg::WORDS_PER_ROW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  curov_in_if.sink                        in_ch,
  curov_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  curov_pkg::cfg_reg_t             cfg_index,
  input  logic [curov_pkg::CFG_W-1:0]     cfg_wdata
);
  import curov_pkg::*;

`include "assert_macros.svh"

  // Pattern memory geometry. One row of the pattern spans WORDS_PER_ROW words.
  localparam int DEPTH = WORDS_PER_ROW * CURSOR_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DYW   = $clog2(CURSOR_HEIGHT);
  // Wide enough to compare a load address against the depth in either direction.
  localparam int IW    = ((AW > WIDX_W) ? AW : WIDX_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipeline is idle; the block does not enforce this.
  // ---------------------------------------------------------------------------
  logic [HOT_W-1:0] hotspot_x_r;
  logic [HOT_W-1:0] hotspot_y_r;
  logic [DIM_W-1:0] disp_w_r;
  logic [DIM_W-1:0] disp_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hotspot_x_r <= '0;
      hotspot_y_r <= '0;
      disp_w_r    <= DISPLAY_WIDTH_RST;
      disp_h_r    <= DISPLAY_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOTSPOT_X:      hotspot_x_r <= cfg_wdata[HOT_W-1:0];
        REG_HOTSPOT_Y:      hotspot_y_r <= cfg_wdata[HOT_W-1:0];
        REG_DISPLAY_WIDTH:  disp_w_r    <= cfg_wdata[DIM_W-1:0];
        REG_DISPLAY_HEIGHT: disp_h_r    <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves when it is empty or when the stage
  // after it moves, so bubbles are squeezed out even while the output stalls.
  // ---------------------------------------------------------------------------
  logic a_valid_r;
  logic b_valid_r;
  logic out_valid_r;
  logic out_en;
  logic b_en;
  logic a_en;
  logic a_fire;

  assign out_en      = !out_valid_r || out_ch.ready;
  assign b_en        = !b_valid_r || out_en;
  assign a_en        = !a_valid_r || b_en;
  assign a_fire      = a_valid_r && b_en;
  assign in_ch.ready = a_en;

  // ---------------------------------------------------------------------------
  // Stage A: the accepted beat. All state updates (pattern words, cursor
  // position, shown flag) take effect when the beat leaves this stage, so a
  // following pixel beat in stage A always sees them.
  // ---------------------------------------------------------------------------
  op_t                     a_op_r;
  logic [WIDX_W-1:0]       a_idx_r;
  logic [WORD_W-1:0]       a_wdata_r;
  logic signed [PTR_W-1:0] a_ptr_x_r;
  logic signed [PTR_W-1:0] a_ptr_y_r;
  logic [PIX_W-1:0]        a_px_r;
  logic [PIX_W-1:0]        a_py_r;
  logic [RGB_W-1:0]        a_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_en) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && in_ch.valid) begin
      a_op_r    <= in_ch.op;
      a_idx_r   <= in_ch.word_index;
      a_wdata_r <= in_ch.word_data;
      a_ptr_x_r <= in_ch.pointer_x;
      a_ptr_y_r <= in_ch.pointer_y;
      a_px_r    <= in_ch.pixel_x;
      a_py_r    <= in_ch.pixel_y;
      a_rgb_r   <= in_ch.pixel_rgb;
    end
  end

  // Cursor position is the pattern's top left corner: pointer minus hotspot.
  logic signed [13:0] cursor_left_r;
  logic signed [13:0] cursor_top_r;
  logic               cursor_shown_r;
  logic signed [13:0] cursor_left_nxt;
  logic signed [13:0] cursor_top_nxt;

  assign cursor_left_nxt = $signed({a_ptr_x_r[PTR_W-1], a_ptr_x_r})
                         - $signed({{(14-HOT_W){1'b0}}, hotspot_x_r});
  assign cursor_top_nxt  = $signed({a_ptr_y_r[PTR_W-1], a_ptr_y_r})
                         - $signed({{(14-HOT_W){1'b0}}, hotspot_y_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_left_r  <= '0;
      cursor_top_r   <= '0;
      cursor_shown_r <= 1'b0;
    end else if (a_fire) begin
      case (a_op_r)
        OP_PLACE: begin
          cursor_left_r  <= cursor_left_nxt;
          cursor_top_r   <= cursor_top_nxt;
          cursor_shown_r <= 1'b1;
        end
        OP_HIDE: cursor_shown_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // Pixel offset inside the pattern. The pixel is 0..4095 and the corner lies
  // within about +-4127, so fifteen signed bits hold the difference.
  logic signed [14:0] dx;
  logic signed [14:0] dy;
  logic               in_display;
  logic               in_pattern;
  logic [2:0]         wcol;
  logic               col_stored;
  logic [DYW-1:0]     dy_idx;
  logic [AW-1:0]      raddr;
  logic               a_cover;

  assign dx = $signed({3'b000, a_px_r}) - $signed({cursor_left_r[13], cursor_left_r});
  assign dy = $signed({3'b000, a_py_r}) - $signed({cursor_top_r[13], cursor_top_r});

  // A display size above the maximum acts as the maximum.
  assign in_display = ({2'b00, a_px_r} < {1'b0, disp_w_r})
                   && ({2'b00, a_px_r} < 14'(MAX_DISPLAY_DIM))
                   && ({2'b00, a_py_r} < {1'b0, disp_h_r})
                   && ({2'b00, a_py_r} < 14'(MAX_DISPLAY_DIM));

  assign in_pattern = !dx[14] && (dx < 15'(CURSOR_WIDTH))
                   && !dy[14] && (dy < 15'(CURSOR_HEIGHT));

  // Sixteen codes per word; a column whose word lies past the stored words of
  // its row is transparent.
  assign wcol       = dx[6:4];
  assign col_stored = {29'd0, wcol} < 32'(WORDS_PER_ROW);
  assign dy_idx     = dy[DYW-1:0];
  assign raddr      = AW'(32'(dy_idx) * 32'(WORDS_PER_ROW) + 32'(wcol));
  assign a_cover    = cursor_shown_r && in_display && in_pattern && col_stored;

  // Pattern memory: one write port driven by load beats, one registered read
  // port addressed by every beat that leaves stage A.
  logic [WORD_W-1:0] pattern_mem [DEPTH];
  logic [IW-1:0]     load_idx;
  logic              load_ok;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] mem_q_r;

  assign load_idx = IW'(a_idx_r);
  assign load_ok  = load_idx < IW'(DEPTH);
  assign waddr    = load_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (a_fire && (a_op_r == OP_LOAD) && load_ok) begin
      pattern_mem[waddr] <= a_wdata_r;
    end
    if (a_fire) begin
      mem_q_r <= pattern_mem[raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: carries the pixel color and coverage alongside the memory word.
  // ---------------------------------------------------------------------------
  logic             b_pix_r;
  logic             b_cover_r;
  logic [3:0]       b_pos_r;
  logic [RGB_W-1:0] b_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_pix_r   <= (a_op_r == OP_PIXEL);
      b_cover_r <= (a_op_r == OP_PIXEL) && a_cover;
      b_pos_r   <= dx[3:0];
      b_rgb_r   <= (a_op_r == OP_PIXEL) ? a_rgb_r : '0;
    end
  end

  // The leftmost pixel sits in the top two bits: shift is 30 - 2 * position.
  code_t            b_code;
  logic             b_hit;
  logic [RGB_W-1:0] b_color;

  assign b_code = code_t'(mem_q_r[{~b_pos_r, 1'b0} +: 2]);

  always_comb begin
    b_hit   = 1'b0;
    b_color = b_rgb_r;
    if (b_cover_r) begin
      case (b_code)
        CODE_CLEAR: ;
        CODE_WHITE: begin
          b_hit   = 1'b1;
          b_color = RGB_WHITE;
        end
        default: begin
          b_hit   = 1'b1;
          b_color = RGB_BLACK;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic [RGB_W-1:0] out_rgb_r;
  logic             out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && b_valid_r) begin
      out_rgb_r <= b_color;
      out_hit_r <= b_hit;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.rgb_out    = out_rgb_r;
  assign out_ch.cursor_hit = out_hit_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_hit_color, (!out_valid_r || !out_hit_r || (out_rgb_r == RGB_WHITE) || (out_rgb_r == RGB_BLACK)), "cursor hit with a color other than black or white")
  `ASSERT_NEXT(a_hide_clears, (a_fire && (a_op_r == OP_HIDE)), !cursor_shown_r, "cursor still shown after a hide beat")
  `ASSERT_NEXT(a_nopix_zero, (b_valid_r && out_en && !b_pix_r), ((out_rgb_r == RGB_BLACK) && !out_hit_r), "non-pixel beat produced color or hit")
  `ASSERT_NEXT(a_uncovered_nohit, (b_valid_r && out_en && !b_cover_r), !out_hit_r, "hit reported for a pixel the cursor does not cover")

endmodule
